FILE: src/mlp_relu_softmax_train_defines.svh
// Assertion macros for the checks in the engine top.
`ifndef MLP_RELU_SOFTMAX_TRAIN_DEFINES_SVH
`define MLP_RELU_SOFTMAX_TRAIN_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define MRS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define MRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/mrs_pkg.sv
// Types, codes and helper functions of the MLP engine.
package mrs_pkg;

  localparam logic [2:0] FN_WRITE    = 3'd0;
  localparam logic [2:0] FN_LOAD_IN  = 3'd1;
  localparam logic [2:0] FN_INFER    = 3'd2;
  localparam logic [2:0] FN_LOAD_TGT = 3'd3;
  localparam logic [2:0] FN_TRAIN    = 3'd4;
  localparam logic [2:0] FN_READ     = 3'd5;

  localparam int          Q_ONE     = 4096;   // 1.0 in Q4.12
  localparam logic [12:0] LR_RESET  = 13'd410; // ~0.1
  localparam int          EXP_SHIFT = 8;      // table step 1/16
  localparam longint unsigned EXP_RATIO = 64'd1008687096;

  typedef enum logic [5:0] {
    ST_IDLE, ST_DECODE, ST_RD_OUT,
    ST_H_B0, ST_H_B1, ST_H_M0, ST_H_M1, ST_H_M2, ST_H_WR,
    ST_O_B0, ST_O_B1, ST_O_M0, ST_O_M1, ST_O_M2, ST_O_WR,
    ST_MX_0, ST_MX_1, ST_MX_2, ST_MX_3,
    ST_EX_0, ST_EX_1,
    ST_DV_0, ST_DV_1, ST_DV_2, ST_DV_3,
    ST_E_0, ST_E_1, ST_E_2,
    ST_HE_0, ST_HE_M0, ST_HE_M1, ST_HE_M2, ST_HE_WR,
    ST_GO_0, ST_GO_1, ST_GO_2,
    ST_UO_M0, ST_UO_M1, ST_UO_M2, ST_UO_B0, ST_UO_B1,
    ST_GH_0, ST_GH_1, ST_GH_2,
    ST_UH_M0, ST_UH_M1, ST_UH_M2, ST_UH_B0, ST_UH_B1
  } state_t;

  typedef enum logic [2:0] {
    MUL_X_W, MUL_H_W, MUL_DIFF, MUL_OE_W, MUL_LR_OE, MUL_LR_HE, MUL_G_H, MUL_G_X
  } mul_op_t;

  typedef enum logic [1:0] {ACC_HOLD, ACC_BIAS, ACC_CLR, ACC_ADD} acc_op_t;
  typedef enum logic [2:0] {PA_ITEM, PA_WIH, PA_WHO, PA_BH, PA_BO} pm_asel_t;
  typedef enum logic [1:0] {PW_ITEM, PW_UPD, PW_BIAS} pm_wsel_t;
  typedef enum logic [1:0] {TOP_HOLD, TOP_LOAD, TOP_MAX} top_op_t;
  typedef enum logic {OS_PROB, OS_READ} out_sel_t;

  typedef struct packed {
    logic     latch;
    logic     pm_re;
    logic     pm_we;
    pm_asel_t pm_asel;
    pm_wsel_t pm_wsel;
    logic     mul_en;
    mul_op_t  mul_op;
    acc_op_t  acc_op;
    logic     g_load;
    logic     x_we;
    logic     t_we;
    logic     h_we;
    logic     lg_we;
    logic     oe_we;
    logic     he_we;
    logic     ex_we;
    logic     sum_clr;
    top_op_t  top_op;
    logic     div_start;
    logic     p_we;
    logic     out_load;
    out_sel_t out_sel;
  } cmd_t;

  typedef struct packed {
    logic addr_pm_ok;
    logic addr_x_ok;
    logic addr_t_ok;
    logic div_busy;
    logic out_free;
  } sts_t;

  function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
    if (v > 40'sd32767) begin
      return 16'sh7fff;
    end else if (v < -40'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  // exp(-k/16) in Q4.12 via the fixed-point recurrence; elaboration only
  function automatic logic [15:0] exp_entry(input int k);
    longint unsigned e;
    longint unsigned r;
    e = 64'd1 << 30;
    for (int n = 0; n < k; n++) begin
      e = (e * EXP_RATIO + (64'd1 << 29)) >> 30;
    end
    r = (e + (64'd1 << 17)) >> 18;
    return r[15:0];
  endfunction

endpackage

FILE: src/mrs_ctrl.sv
// Sequencer of the MLP engine: decodes items and steps the MAC loops.
module mrs_ctrl #(
  parameter int IN_CNT  = 18,
  parameter int HID_CNT = 100,
  parameter int OUT_CNT = 9,
  localparam int XW = (IN_CNT > 1) ? $clog2(IN_CNT) : 1,
  localparam int HW = (HID_CNT > 1) ? $clog2(HID_CNT) : 1,
  localparam int KW = $clog2(OUT_CNT)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [2:0]          in_func,
  output logic                in_stall,
  input  mrs_pkg::sts_t       sts,
  output mrs_pkg::cmd_t       cmd,
  output logic [HW-1:0]       ci,
  output logic [XW-1:0]       cj,
  output logic [KW-1:0]       ck
);

  mrs_pkg::state_t state_r, state_nxt;
  logic [2:0]    func_r, func_nxt;
  logic [HW-1:0] ci_r, ci_nxt;
  logic [XW-1:0] cj_r, cj_nxt;
  logic [KW-1:0] ck_r, ck_nxt;
  logic ci_last, cj_last, ck_last;

  assign ci_last = (ci_r == HW'(HID_CNT - 1));
  assign cj_last = (cj_r == XW'(IN_CNT - 1));
  assign ck_last = (ck_r == KW'(OUT_CNT - 1));
  assign ci = ci_r;
  assign cj = cj_r;
  assign ck = ck_r;
  assign in_stall = (state_r != mrs_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mrs_pkg::ST_IDLE;
      func_r  <= '0;
      ci_r    <= '0;
      cj_r    <= '0;
      ck_r    <= '0;
    end else begin
      state_r <= state_nxt;
      func_r  <= func_nxt;
      ci_r    <= ci_nxt;
      cj_r    <= cj_nxt;
      ck_r    <= ck_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    func_nxt  = func_r;
    ci_nxt    = ci_r;
    cj_nxt    = cj_r;
    ck_nxt    = ck_r;
    cmd       = '0;
    case (state_r)
      mrs_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          func_nxt  = in_func;
          state_nxt = mrs_pkg::ST_DECODE;
        end
      end
      mrs_pkg::ST_DECODE: begin
        state_nxt = mrs_pkg::ST_IDLE;
        case (func_r)
          mrs_pkg::FN_WRITE: begin
            cmd.pm_we   = sts.addr_pm_ok;
            cmd.pm_asel = mrs_pkg::PA_ITEM;
            cmd.pm_wsel = mrs_pkg::PW_ITEM;
          end
          mrs_pkg::FN_LOAD_IN:  cmd.x_we = sts.addr_x_ok;
          mrs_pkg::FN_LOAD_TGT: cmd.t_we = sts.addr_t_ok;
          mrs_pkg::FN_READ: begin
            cmd.pm_re   = sts.addr_pm_ok;
            cmd.pm_asel = mrs_pkg::PA_ITEM;
            state_nxt   = mrs_pkg::ST_RD_OUT;
          end
          mrs_pkg::FN_INFER: begin
            ci_nxt    = '0;
            state_nxt = mrs_pkg::ST_H_B0;
          end
          mrs_pkg::FN_TRAIN: begin
            ck_nxt    = '0;
            state_nxt = mrs_pkg::ST_E_0;
          end
          default: state_nxt = mrs_pkg::ST_IDLE;
        endcase
      end
      mrs_pkg::ST_RD_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = mrs_pkg::OS_READ;
          state_nxt    = mrs_pkg::ST_IDLE;
        end
      end
      // hidden layer
      mrs_pkg::ST_H_B0: begin
        cmd.pm_re   = 1'b1;
        cmd.pm_asel = mrs_pkg::PA_BH;
        cj_nxt      = '0;
        state_nxt   = mrs_pkg::ST_H_B1;
      end
      mrs_pkg::ST_H_B1: begin
        cmd.acc_op = mrs_pkg::ACC_BIAS;
        state_nxt  = mrs_pkg::ST_H_M0;
      end
      mrs_pkg::ST_H_M0: begin
        cmd.pm_re   = 1'b1;
        cmd.pm_asel = mrs_pkg::PA_WIH;
        state_nxt   = mrs_pkg::ST_H_M1;
      end
      mrs_pkg::ST_H_M1: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = mrs_pkg::MUL_X_W;
        state_nxt  = mrs_pkg::ST_H_M2;
      end
      mrs_pkg::ST_H_M2: begin
        cmd.acc_op = mrs_pkg::ACC_ADD;
        if (cj_last) begin
          state_nxt = mrs_pkg::ST_H_WR;
        end else begin
          cj_nxt    = cj_r + 1'b1;
          state_nxt = mrs_pkg::ST_H_M0;
        end
      end
      mrs_pkg::ST_H_WR: begin
        cmd.h_we = 1'b1;
        if (ci_last) begin
          ci_nxt    = '0;
          ck_nxt    = '0;
          state_nxt = mrs_pkg::ST_O_B0;
        end else begin
          ci_nxt    = ci_r + 1'b1;
          state_nxt = mrs_pkg::ST_H_B0;
        end
      end
      // output layer
      mrs_pkg::ST_O_B0: begin
        cmd.pm_re   = 1'b1;
        cmd.pm_asel = mrs_pkg::PA_BO;
        ci_nxt      = '0;
        state_nxt   = mrs_pkg::ST_O_B1;
      end
      mrs_pkg::ST_O_B1: begin
        cmd.acc_op = mrs_pkg::ACC_BIAS;
        state_nxt  = mrs_pkg::ST_O_M0;
      end
      mrs_pkg::ST_O_M0: begin
        cmd.pm_re   = 1'b1;
        cmd.pm_asel = mrs_pkg::PA_WHO;
        state_nxt   = mrs_pkg::ST_O_M1;
      end
      mrs_pkg::ST_O_M1: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = mrs_pkg::MUL_H_W;
        state_nxt  = mrs_pkg::ST_O_M2;
      end
      mrs_pkg::ST_O_M2: begin
        cmd.acc_op = mrs_pkg::ACC_ADD;
        if (ci_last) begin
          state_nxt = mrs_pkg::ST_O_WR;
        end else begin
          ci_nxt    = ci_r + 1'b1;
          state_nxt = mrs_pkg::ST_O_M0;
        end
      end
      mrs_pkg::ST_O_WR: begin
        cmd.lg_we = 1'b1;
        if (ck_last) begin
          ck_nxt    = '0;
          state_nxt = mrs_pkg::ST_MX_0;
        end else begin
          ck_nxt    = ck_r + 1'b1;
          state_nxt = mrs_pkg::ST_O_B0;
        end
      end
      // max of the logits
      mrs_pkg::ST_MX_0: state_nxt = mrs_pkg::ST_MX_1;
      mrs_pkg::ST_MX_1: begin
        cmd.top_op  = mrs_pkg::TOP_LOAD;
        cmd.sum_clr = 1'b1;
        ck_nxt      = ck_r + 1'b1;
        state_nxt   = mrs_pkg::ST_MX_2;
      end
      mrs_pkg::ST_MX_2: state_nxt = mrs_pkg::ST_MX_3;
      mrs_pkg::ST_MX_3: begin
        cmd.top_op = mrs_pkg::TOP_MAX;
        if (ck_last) begin
          ck_nxt    = '0;
          state_nxt = mrs_pkg::ST_EX_0;
        end else begin
          ck_nxt    = ck_r + 1'b1;
          state_nxt = mrs_pkg::ST_MX_2;
        end
      end
      // exp lookup and sum
      mrs_pkg::ST_EX_0: state_nxt = mrs_pkg::ST_EX_1;
      mrs_pkg::ST_EX_1: begin
        cmd.ex_we = 1'b1;
        if (ck_last) begin
          ck_nxt    = '0;
          state_nxt = mrs_pkg::ST_DV_0;
        end else begin
          ck_nxt    = ck_r + 1'b1;
          state_nxt = mrs_pkg::ST_EX_0;
        end
      end
      // normalize and emit
      mrs_pkg::ST_DV_0: state_nxt = mrs_pkg::ST_DV_1;
      mrs_pkg::ST_DV_1: begin
        cmd.div_start = 1'b1;
        state_nxt     = mrs_pkg::ST_DV_2;
      end
      mrs_pkg::ST_DV_2: begin
        if (!sts.div_busy) begin
          state_nxt = mrs_pkg::ST_DV_3;
        end
      end
      mrs_pkg::ST_DV_3: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = mrs_pkg::OS_PROB;
          cmd.p_we     = 1'b1;
          if (ck_last) begin
            state_nxt = mrs_pkg::ST_IDLE;
          end else begin
            ck_nxt    = ck_r + 1'b1;
            state_nxt = mrs_pkg::ST_DV_0;
          end
        end
      end
      // output errors
      mrs_pkg::ST_E_0: state_nxt = mrs_pkg::ST_E_1;
      mrs_pkg::ST_E_1: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = mrs_pkg::MUL_DIFF;
        state_nxt  = mrs_pkg::ST_E_2;
      end
      mrs_pkg::ST_E_2: begin
        cmd.oe_we = 1'b1;
        if (ck_last) begin
          ci_nxt    = '0;
          state_nxt = mrs_pkg::ST_HE_0;
        end else begin
          ck_nxt    = ck_r + 1'b1;
          state_nxt = mrs_pkg::ST_E_0;
        end
      end
      // hidden errors, with the old output weights
      mrs_pkg::ST_HE_0: begin
        cmd.acc_op = mrs_pkg::ACC_CLR;
        ck_nxt     = '0;
        state_nxt  = mrs_pkg::ST_HE_M0;
      end
      mrs_pkg::ST_HE_M0: begin
        cmd.pm_re   = 1'b1;
        cmd.pm_asel = mrs_pkg::PA_WHO;
        state_nxt   = mrs_pkg::ST_HE_M1;
      end
      mrs_pkg::ST_HE_M1: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = mrs_pkg::MUL_OE_W;
        state_nxt  = mrs_pkg::ST_HE_M2;
      end
      mrs_pkg::ST_HE_M2: begin
        cmd.acc_op = mrs_pkg::ACC_ADD;
        if (ck_last) begin
          state_nxt = mrs_pkg::ST_HE_WR;
        end else begin
          ck_nxt    = ck_r + 1'b1;
          state_nxt = mrs_pkg::ST_HE_M0;
        end
      end
      mrs_pkg::ST_HE_WR: begin
        cmd.he_we = 1'b1;
        if (ci_last) begin
          ck_nxt    = '0;
          state_nxt = mrs_pkg::ST_GO_0;
        end else begin
          ci_nxt    = ci_r + 1'b1;
          state_nxt = mrs_pkg::ST_HE_0;
        end
      end
      // output weight and bias update
      mrs_pkg::ST_GO_0: state_nxt = mrs_pkg::ST_GO_1;
      mrs_pkg::ST_GO_1: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = mrs_pkg::MUL_LR_OE;
        state_nxt  = mrs_pkg::ST_GO_2;
      end
      mrs_pkg::ST_GO_2: begin
        cmd.g_load = 1'b1;
        ci_nxt     = '0;
        state_nxt  = mrs_pkg::ST_UO_M0;
      end
      mrs_pkg::ST_UO_M0: begin
        cmd.pm_re   = 1'b1;
        cmd.pm_asel = mrs_pkg::PA_WHO;
        state_nxt   = mrs_pkg::ST_UO_M1;
      end
      mrs_pkg::ST_UO_M1: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = mrs_pkg::MUL_G_H;
        state_nxt  = mrs_pkg::ST_UO_M2;
      end
      mrs_pkg::ST_UO_M2: begin
        cmd.pm_we   = 1'b1;
        cmd.pm_asel = mrs_pkg::PA_WHO;
        cmd.pm_wsel = mrs_pkg::PW_UPD;
        if (ci_last) begin
          state_nxt = mrs_pkg::ST_UO_B0;
        end else begin
          ci_nxt    = ci_r + 1'b1;
          state_nxt = mrs_pkg::ST_UO_M0;
        end
      end
      mrs_pkg::ST_UO_B0: begin
        cmd.pm_re   = 1'b1;
        cmd.pm_asel = mrs_pkg::PA_BO;
        state_nxt   = mrs_pkg::ST_UO_B1;
      end
      mrs_pkg::ST_UO_B1: begin
        cmd.pm_we   = 1'b1;
        cmd.pm_asel = mrs_pkg::PA_BO;
        cmd.pm_wsel = mrs_pkg::PW_BIAS;
        if (ck_last) begin
          ci_nxt    = '0;
          state_nxt = mrs_pkg::ST_GH_0;
        end else begin
          ck_nxt    = ck_r + 1'b1;
          state_nxt = mrs_pkg::ST_GO_0;
        end
      end
      // input weight and hidden bias update
      mrs_pkg::ST_GH_0: state_nxt = mrs_pkg::ST_GH_1;
      mrs_pkg::ST_GH_1: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = mrs_pkg::MUL_LR_HE;
        state_nxt  = mrs_pkg::ST_GH_2;
      end
      mrs_pkg::ST_GH_2: begin
        cmd.g_load = 1'b1;
        cj_nxt     = '0;
        state_nxt  = mrs_pkg::ST_UH_M0;
      end
      mrs_pkg::ST_UH_M0: begin
        cmd.pm_re   = 1'b1;
        cmd.pm_asel = mrs_pkg::PA_WIH;
        state_nxt   = mrs_pkg::ST_UH_M1;
      end
      mrs_pkg::ST_UH_M1: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = mrs_pkg::MUL_G_X;
        state_nxt  = mrs_pkg::ST_UH_M2;
      end
      mrs_pkg::ST_UH_M2: begin
        cmd.pm_we   = 1'b1;
        cmd.pm_asel = mrs_pkg::PA_WIH;
        cmd.pm_wsel = mrs_pkg::PW_UPD;
        if (cj_last) begin
          state_nxt = mrs_pkg::ST_UH_B0;
        end else begin
          cj_nxt    = cj_r + 1'b1;
          state_nxt = mrs_pkg::ST_UH_M0;
        end
      end
      mrs_pkg::ST_UH_B0: begin
        cmd.pm_re   = 1'b1;
        cmd.pm_asel = mrs_pkg::PA_BH;
        state_nxt   = mrs_pkg::ST_UH_B1;
      end
      mrs_pkg::ST_UH_B1: begin
        cmd.pm_we   = 1'b1;
        cmd.pm_asel = mrs_pkg::PA_BH;
        cmd.pm_wsel = mrs_pkg::PW_BIAS;
        if (ci_last) begin
          state_nxt = mrs_pkg::ST_IDLE;
        end else begin
          ci_nxt    = ci_r + 1'b1;
          state_nxt = mrs_pkg::ST_GH_0;
        end
      end
      default: state_nxt = mrs_pkg::ST_IDLE;
    endcase
  end

endmodule

FILE: src/mrs_dp.sv
// Datapath of the MLP engine: memories, shared MAC, exp table, divider, output register.
module mrs_dp #(
  parameter int IN_CNT    = 18,
  parameter int HID_CNT   = 100,
  parameter int OUT_CNT   = 9,
  parameter int EXP_DEPTH = 256,
  localparam int XW = (IN_CNT > 1) ? $clog2(IN_CNT) : 1,
  localparam int HW = (HID_CNT > 1) ? $clog2(HID_CNT) : 1,
  localparam int KW = $clog2(OUT_CNT)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [11:0]        in_address,
  input  logic signed [15:0] in_value,
  input  logic               cfg_wr_en,
  input  logic [12:0]        cfg_wr_data,
  input  logic               out_stall,
  output logic               out_valid,
  output logic signed [15:0] out_result_value,
  output logic [11:0]        out_result_index,
  output logic               out_last_result,
  input  mrs_pkg::cmd_t      cmd,
  output mrs_pkg::sts_t      sts,
  input  logic [HW-1:0]      ci,
  input  logic [XW-1:0]      cj,
  input  logic [KW-1:0]      ck
);

  localparam int WHO_BASE    = IN_CNT * HID_CNT;
  localparam int BH_BASE     = WHO_BASE + HID_CNT * OUT_CNT;
  localparam int BO_BASE     = BH_BASE + HID_CNT;
  localparam int PARAM_COUNT = BO_BASE + OUT_CNT;
  localparam int PW          = $clog2(PARAM_COUNT);
  localparam int EW          = $clog2(EXP_DEPTH);
  localparam int SUM_W       = 13 + $clog2(OUT_CNT);
  localparam int NUM_W       = 26;
  localparam int CW          = $clog2(NUM_W + 1);
  localparam int UNIFORM     = mrs_pkg::Q_ONE / OUT_CNT;

  // item registers
  logic [11:0]        addr_r;
  logic signed [15:0] val_r;
  logic [12:0]        lr_r;

  // memories
  logic signed [15:0] pm_mem [PARAM_COUNT];
  logic signed [15:0] x_mem  [IN_CNT];
  logic signed [15:0] h_mem  [HID_CNT];
  logic signed [15:0] he_mem [HID_CNT];
  logic signed [31:0] lg_mem [OUT_CNT];
  logic [15:0]        ex_mem [OUT_CNT];
  logic signed [15:0] p_mem  [OUT_CNT];
  logic signed [15:0] t_mem  [OUT_CNT];
  logic signed [15:0] oe_mem [OUT_CNT];

  logic signed [15:0] pm_rd_r, x_rd_r, h_rd_r, he_rd_r, p_rd_r, t_rd_r, oe_rd_r;
  logic signed [31:0] lg_rd_r;
  logic [15:0]        ex_rd_r;

  logic [15:0] exp_tab [EXP_DEPTH];

  logic [31:0]        pm_addr_full;
  logic [PW-1:0]      pm_addr;
  logic signed [15:0] pm_wd;

  logic signed [17:0] mul_a, mul_b;
  logic signed [35:0] mul_r;
  logic signed [23:0] prod_sh;
  logic signed [31:0] acc_r;
  logic signed [17:0] g_r;
  logic signed [31:0] top_r;
  logic [SUM_W-1:0]   sum_r;

  logic signed [16:0] val_ext, val_abs, diff;
  logic signed [32:0] delta;
  logic               delta_ok;
  logic [15:0]        exp_val;

  logic [NUM_W-1:0]   div_num_r, div_q_r;
  logic [SUM_W-1:0]   div_rem_r;
  logic [SUM_W:0]     div_trial;
  logic [CW-1:0]      div_cnt_r;
  logic               div_busy_r;

  logic               out_valid_r;
  logic signed [15:0] out_value_r;
  logic [11:0]        out_index_r;
  logic               out_last_r;

  for (genvar g = 0; g < EXP_DEPTH; g++) begin : g_exp
    assign exp_tab[g] = mrs_pkg::exp_entry(g);
  end

  assign sts.addr_pm_ok = (addr_r < 12'(PARAM_COUNT));
  assign sts.addr_x_ok  = (addr_r < 12'(IN_CNT));
  assign sts.addr_t_ok  = (addr_r < 12'(OUT_CNT));
  assign sts.div_busy   = div_busy_r;
  assign sts.out_free   = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r <= mrs_pkg::LR_RESET;
    end else if (cfg_wr_en) begin
      lr_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      addr_r <= in_address;
      val_r  <= in_value;
    end
  end

  // parameter memory address and write data
  always_comb begin
    case (cmd.pm_asel)
      mrs_pkg::PA_ITEM: pm_addr_full = 32'(addr_r);
      mrs_pkg::PA_WIH:  pm_addr_full = 32'(cj) * 32'(HID_CNT) + 32'(ci);
      mrs_pkg::PA_WHO:  pm_addr_full = 32'(WHO_BASE) + 32'(ci) * 32'(OUT_CNT) + 32'(ck);
      mrs_pkg::PA_BH:   pm_addr_full = 32'(BH_BASE) + 32'(ci);
      mrs_pkg::PA_BO:   pm_addr_full = 32'(BO_BASE) + 32'(ck);
      default:          pm_addr_full = '0;
    endcase
  end
  assign pm_addr = pm_addr_full[PW-1:0];

  assign prod_sh = mul_r[35:12];

  always_comb begin
    case (cmd.pm_wsel)
      mrs_pkg::PW_ITEM: pm_wd = val_r;
      mrs_pkg::PW_UPD:  pm_wd = mrs_pkg::sat16(40'(pm_rd_r) - 40'(prod_sh));
      mrs_pkg::PW_BIAS: pm_wd = mrs_pkg::sat16(40'(pm_rd_r) - 40'(g_r));
      default:          pm_wd = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.pm_we) begin
      pm_mem[pm_addr] <= pm_wd;
    end
    if (cmd.pm_re) begin
      pm_rd_r <= pm_mem[pm_addr];
    end
  end

  // small stores, read every cycle at the loop counters
  always_ff @(posedge clk) begin
    if (cmd.x_we) begin
      x_mem[addr_r[XW-1:0]] <= val_r;
    end
    if (cmd.t_we) begin
      t_mem[addr_r[KW-1:0]] <= val_r;
    end
    if (cmd.h_we) begin
      h_mem[ci] <= (acc_r > 32'sd0) ? mrs_pkg::sat16(40'(acc_r)) : 16'sd0;
    end
    if (cmd.he_we) begin
      he_mem[ci] <= (h_rd_r > 16'sd0) ? mrs_pkg::sat16(40'(acc_r)) : 16'sd0;
    end
    if (cmd.lg_we) begin
      lg_mem[ck] <= acc_r;
    end
    if (cmd.ex_we) begin
      ex_mem[ck] <= exp_val;
    end
    if (cmd.p_we) begin
      p_mem[ck] <= div_q_r[15:0];
    end
    if (cmd.oe_we) begin
      oe_mem[ck] <= mrs_pkg::sat16(40'(prod_sh));
    end
    x_rd_r  <= x_mem[cj];
    h_rd_r  <= h_mem[ci];
    he_rd_r <= he_mem[ci];
    lg_rd_r <= lg_mem[ck];
    ex_rd_r <= ex_mem[ck];
    p_rd_r  <= p_mem[ck];
    t_rd_r  <= t_mem[ck];
    oe_rd_r <= oe_mem[ck];
  end

  // shared multiplier
  assign val_ext = 17'(val_r);
  assign val_abs = val_ext[16] ? -val_ext : val_ext;
  assign diff    = 17'(p_rd_r) - 17'(t_rd_r);

  always_comb begin
    case (cmd.mul_op)
      mrs_pkg::MUL_X_W:   begin mul_a = 18'(x_rd_r);  mul_b = 18'(pm_rd_r); end
      mrs_pkg::MUL_H_W:   begin mul_a = 18'(h_rd_r);  mul_b = 18'(pm_rd_r); end
      mrs_pkg::MUL_DIFF:  begin mul_a = 18'(diff);    mul_b = {1'b0, val_abs}; end
      mrs_pkg::MUL_OE_W:  begin mul_a = 18'(oe_rd_r); mul_b = 18'(pm_rd_r); end
      mrs_pkg::MUL_LR_OE: begin mul_a = {5'b0, lr_r}; mul_b = 18'(oe_rd_r); end
      mrs_pkg::MUL_LR_HE: begin mul_a = {5'b0, lr_r}; mul_b = 18'(he_rd_r); end
      mrs_pkg::MUL_G_H:   begin mul_a = g_r;          mul_b = 18'(h_rd_r); end
      mrs_pkg::MUL_G_X:   begin mul_a = g_r;          mul_b = 18'(x_rd_r); end
      default:            begin mul_a = '0;           mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      mul_r <= mul_a * mul_b;
    end
    if (cmd.g_load) begin
      g_r <= prod_sh[17:0];
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.acc_op)
      mrs_pkg::ACC_BIAS: acc_r <= 32'(pm_rd_r);
      mrs_pkg::ACC_CLR:  acc_r <= '0;
      mrs_pkg::ACC_ADD:  acc_r <= acc_r + 32'(prod_sh);
      default:           acc_r <= acc_r;
    endcase
  end

  // softmax: max, exp lookup, sum
  assign delta    = 33'(top_r) - 33'(lg_rd_r);
  assign delta_ok = (delta[32:mrs_pkg::EXP_SHIFT] < (33 - mrs_pkg::EXP_SHIFT)'(EXP_DEPTH));
  assign exp_val  = delta_ok ? exp_tab[delta[mrs_pkg::EXP_SHIFT+EW-1:mrs_pkg::EXP_SHIFT]]
                             : 16'd0;

  always_ff @(posedge clk) begin
    case (cmd.top_op)
      mrs_pkg::TOP_LOAD: top_r <= lg_rd_r;
      mrs_pkg::TOP_MAX:  top_r <= (lg_rd_r > top_r) ? lg_rd_r : top_r;
      default:           top_r <= top_r;
    endcase
    if (cmd.sum_clr) begin
      sum_r <= '0;
    end else if (cmd.ex_we) begin
      sum_r <= sum_r + SUM_W'(exp_val);
    end
  end

  // restoring divider, one quotient bit per cycle
  assign div_trial = {div_rem_r, div_num_r[NUM_W-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
      div_cnt_r  <= '0;
    end else if (cmd.div_start) begin
      div_rem_r <= '0;
      div_q_r   <= NUM_W'(UNIFORM);
      div_num_r <= NUM_W'({ex_rd_r, 12'b0}) + NUM_W'(sum_r >> 1);
      div_cnt_r <= CW'(NUM_W);
      div_busy_r <= (sum_r != '0);
    end else if (div_busy_r) begin
      if (div_trial >= {1'b0, sum_r}) begin
        div_rem_r <= SUM_W'(div_trial - {1'b0, sum_r});
        div_q_r   <= {div_q_r[NUM_W-2:0], 1'b1};
      end else begin
        div_rem_r <= div_trial[SUM_W-1:0];
        div_q_r   <= {div_q_r[NUM_W-2:0], 1'b0};
      end
      div_num_r  <= {div_num_r[NUM_W-2:0], 1'b0};
      div_cnt_r  <= div_cnt_r - 1'b1;
      div_busy_r <= (div_cnt_r != CW'(1));
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (cmd.out_sel == mrs_pkg::OS_READ) begin
        out_value_r <= sts.addr_pm_ok ? pm_rd_r : 16'sd0;
        out_index_r <= addr_r;
        out_last_r  <= 1'b1;
      end else begin
        out_value_r <= div_q_r[15:0];
        out_index_r <= 12'(ck);
        out_last_r  <= (ck == KW'(OUT_CNT - 1));
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_result_index = out_index_r;
  assign out_last_result  = out_last_r;

endmodule

FILE: src/mlp_relu_softmax_train.sv
// MLP engine top: one hidden ReLU layer, softmax outputs, SGD training, one shared MAC.
// Items are taken one at a time; a read also waits until the output register is free.
// Each layer loop steps the single MAC through read, multiply and accumulate or write-back;
// the softmax normalization uses a bit-serial divider.
// Synchronous active-low reset clears control and sets learn_rate to 410; stores are not cleared.
`include "mlp_relu_softmax_train_defines.svh"

module mlp_relu_softmax_train #(
  parameter int INPUT_COUNT     = 18,
  parameter int HIDDEN_COUNT    = 100,
  parameter int OUTPUT_COUNT    = 9,
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  // item input
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_func,
  input  logic [11:0]        in_address,
  input  logic signed [15:0] in_value,
  // learn_rate register
  input  logic               cfg_wr_en,
  input  logic [12:0]        cfg_wr_data,
  // result output
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_result_value,
  output logic [11:0]        out_result_index,
  output logic               out_last_result
);

  localparam int XW = (INPUT_COUNT > 1) ? $clog2(INPUT_COUNT) : 1;
  localparam int HW = (HIDDEN_COUNT > 1) ? $clog2(HIDDEN_COUNT) : 1;
  localparam int KW = $clog2(OUTPUT_COUNT);

  mrs_pkg::cmd_t cmd;
  mrs_pkg::sts_t sts;
  logic [HW-1:0] ci;
  logic [XW-1:0] cj;
  logic [KW-1:0] ck;

  // Sequencer: decodes each item and walks the layer loops of MAC steps.
  mrs_ctrl #(
    .IN_CNT  (INPUT_COUNT),
    .HID_CNT (HIDDEN_COUNT),
    .OUT_CNT (OUTPUT_COUNT)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd),
    .ci       (ci),
    .cj       (cj),
    .ck       (ck)
  );

  // Datapath: parameter memory, activation/error stores, MAC, softmax and result register.
  mrs_dp #(
    .IN_CNT    (INPUT_COUNT),
    .HID_CNT   (HIDDEN_COUNT),
    .OUT_CNT   (OUTPUT_COUNT),
    .EXP_DEPTH (EXP_TABLE_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_address       (in_address),
    .in_value         (in_value),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_result_value (out_result_value),
    .out_result_index (out_result_index),
    .out_last_result  (out_last_result),
    .cmd              (cmd),
    .sts              (sts),
    .ci               (ci),
    .cj               (cj),
    .ck               (ck)
  );

  // an accepted item always closes the input for its decode cycle
  `MRS_ASSERT_NEXT(a_accept_closes, in_valid && !in_stall, in_stall, "input open after accept")
  // a result is never loaded over one still held by the consumer
  `MRS_ASSERT_NOW(a_load_free, cmd.out_load, !out_valid || !out_stall, "result overwritten")
  // the parameter memory port does one access per cycle
  `MRS_ASSERT_NOW(a_pm_port, cmd.pm_we, !cmd.pm_re, "param read and write together")

endmodule
